@@ src/pmfe_pkg.sv @@
// Shared types, constants and saturating helpers of the power metering front end.
// No dependencies.
package pmfe_pkg;

  localparam int ADC_WIDTH_DEF = 12;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 24;

  localparam logic [11:0] MID_CODE_RST   = 12'd2048;
  localparam logic [15:0] HPF_COEF_RST   = 16'd65208;
  localparam logic [13:0] PHASE_COEF_RST = 14'd983;
  localparam logic [23:0] V_GAIN_RST     = 24'd2568811;
  localparam logic [23:0] I_GAIN_RST     = 24'd12033;
  localparam logic [15:0] WIN_SMP_RST    = 16'd4000;
  localparam logic [15:0] WIN_MS_RST     = 16'd1000;

  localparam logic [63:0] EPS_Q32 = 64'd4295;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MID_CODE   = 3'd0,
    CFG_HPF_COEF   = 3'd1,
    CFG_PHASE_COEF = 3'd2,
    CFG_V_GAIN     = 3'd3,
    CFG_I_GAIN     = 3'd4,
    CFG_WIN_SMP    = 3'd5,
    CFG_WIN_MS     = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [11:0] mid_code;
    logic [15:0] hpf_coef;
    logic [13:0] phase_coef;
    logic [23:0] voltage_gain;
    logic [23:0] current_gain;
    logic [15:0] window_samples;
    logic [15:0] window_ms;
  } cfg_t;

  // closed window handed from the sample path to the window math
  typedef struct packed {
    logic [63:0]        sum_i;
    logic [63:0]        sum_v;
    logic signed [63:0] sum_x;
    logic [16:0]        n;
  } win_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [63:0] uadd_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  function automatic logic signed [63:0] sadd_sat(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
    logic signed [64:0] s;
    logic signed [63:0] r;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) begin
      r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      r = s[63:0];
    end
    return r;
  endfunction

endpackage

@@ src/pmfe_front.sv @@
// Sample path: mid-rail removal, high-pass, gain, current lag and window sums.
// Depends on pmfe_pkg; pushes closed windows into pmfe_fifo.
module pmfe_front #(
  parameter int AdcWidth = pmfe_pkg::ADC_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pmfe_pkg::cfg_t       cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [AdcWidth-1:0]  current_code_i,
  input  logic [AdcWidth-1:0]  voltage_code_i,
  output logic                 push_o,
  output pmfe_pkg::win_t       push_data_o,
  input  logic                 full_i
);

  localparam int XW = ((AdcWidth > 12) ? AdcWidth : 12) + 1;
  localparam int TW = ((XW + 17 > 32) ? XW + 17 : 32) + 1;
  localparam int PW = TW + 17;

  typedef enum logic [2:0] {F_IDLE, F_HP, F_GAIN, F_LAG, F_MUL, F_ACC} state_e;

  state_e                 state_q;
  logic signed [XW-1:0]   xi_q, xv_q, prev_i_q, prev_v_q;
  logic signed [31:0]     hp_i_q, hp_v_q, ia_q, vv_q, lag_q;
  logic [63:0]            pii_q, pvv_q, sum_i_q, sum_v_q;
  logic signed [63:0]     pvx_q, sum_x_q;
  logic [15:0]            cnt_q;

  function automatic logic signed [31:0] hpf(input logic signed [31:0] y,
                                             input logic signed [XW-1:0] x,
                                             input logic signed [XW-1:0] prev,
                                             input logic [15:0] a);
    logic signed [TW-1:0] t;
    logic signed [PW-1:0] p;
    t = TW'(y) + ((TW'(x) - TW'(prev)) <<< 16);
    p = PW'(t) * $signed({1'b0, a});
    p = p + PW'(32768);
    return pmfe_pkg::sat32(64'(p >>> 16));
  endfunction

  function automatic logic signed [31:0] gain(input logic signed [31:0] y,
                                              input logic [23:0] g);
    logic signed [56:0] p;
    p = 57'(y) * $signed({1'b0, g});
    return pmfe_pkg::sat32(64'(p >>> 24));
  endfunction

  logic signed [XW-1:0] xi, xv;
  logic signed [32:0]   lag_d;
  logic signed [47:0]   lag_m;
  logic signed [33:0]   lag_s;
  logic [63:0]          acc_i, acc_v;
  logic signed [63:0]   acc_x;
  logic [15:0]          cnt_nx, win;
  logic                 close;

  assign xi = $signed({{(XW-AdcWidth){1'b0}}, current_code_i})
            - $signed({{(XW-12){1'b0}}, cfg_i.mid_code});
  assign xv = $signed({{(XW-AdcWidth){1'b0}}, voltage_code_i})
            - $signed({{(XW-12){1'b0}}, cfg_i.mid_code});

  always_comb begin
    lag_d = 33'(lag_q) - 33'(ia_q);
    lag_m = 48'(lag_d) * $signed({1'b0, cfg_i.phase_coef});
    lag_m = lag_m + 48'sd32768;
    lag_s = 34'(ia_q) + 34'(lag_m >>> 16);
  end

  assign acc_i  = pmfe_pkg::uadd_sat(sum_i_q, pii_q);
  assign acc_v  = pmfe_pkg::uadd_sat(sum_v_q, pvv_q);
  assign acc_x  = pmfe_pkg::sadd_sat(sum_x_q, pvx_q);
  assign cnt_nx = cnt_q + 16'd1;
  assign win    = (cfg_i.window_samples == 16'd0) ? 16'd1 : cfg_i.window_samples;
  assign close  = (cnt_nx == 16'd0) || (cnt_nx >= win);

  assign in_ready_o        = (state_q == F_IDLE);
  assign push_o            = (state_q == F_ACC) && close && !full_i;
  assign push_data_o.sum_i = acc_i;
  assign push_data_o.sum_v = acc_v;
  assign push_data_o.sum_x = acc_x;
  assign push_data_o.n     = {(cnt_nx == 16'd0), cnt_nx};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      prev_i_q <= '0;
      prev_v_q <= '0;
      hp_i_q   <= '0;
      hp_v_q   <= '0;
      lag_q    <= '0;
      sum_i_q  <= '0;
      sum_v_q  <= '0;
      sum_x_q  <= '0;
      cnt_q    <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (in_valid_i) begin
            xi_q    <= xi;
            xv_q    <= xv;
            state_q <= F_HP;
          end
        end
        F_HP: begin
          hp_i_q   <= hpf(hp_i_q, xi_q, prev_i_q, cfg_i.hpf_coef);
          hp_v_q   <= hpf(hp_v_q, xv_q, prev_v_q, cfg_i.hpf_coef);
          prev_i_q <= xi_q;
          prev_v_q <= xv_q;
          state_q  <= F_GAIN;
        end
        F_GAIN: begin
          ia_q    <= gain(hp_i_q, cfg_i.current_gain);
          vv_q    <= gain(hp_v_q, cfg_i.voltage_gain);
          state_q <= F_LAG;
        end
        F_LAG: begin
          lag_q   <= pmfe_pkg::sat32(64'(lag_s));
          state_q <= F_MUL;
        end
        F_MUL: begin
          pii_q   <= 64'(64'(lag_q) * 64'(lag_q));
          pvv_q   <= 64'(64'(vv_q) * 64'(vv_q));
          pvx_q   <= 64'(vv_q) * 64'(lag_q);
          state_q <= F_ACC;
        end
        F_ACC: begin
          if (!close) begin
            sum_i_q <= acc_i;
            sum_v_q <= acc_v;
            sum_x_q <= acc_x;
            cnt_q   <= cnt_nx;
            state_q <= F_IDLE;
          end else if (!full_i) begin
            sum_i_q <= '0;
            sum_v_q <= '0;
            sum_x_q <= '0;
            cnt_q   <= '0;
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

@@ src/pmfe_fifo.sv @@
// Two-entry queue of closed windows between the sample path and the window math.
// Depends on pmfe_pkg.
module pmfe_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pmfe_pkg::win_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output pmfe_pkg::win_t pop_data_o
);

  pmfe_pkg::win_t mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count overflow");

endmodule

@@ src/pmfe_back.sv @@
// Window math: serial mean division, integer square roots, power factor, energy.
// Depends on pmfe_pkg; takes windows from pmfe_fifo.
module pmfe_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [15:0]         window_ms_i,
  input  logic                valid_i,
  input  pmfe_pkg::win_t      data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         vrms_o,
  output logic [31:0]         irms_o,
  output logic signed [39:0]  real_power_o,
  output logic signed [15:0]  power_factor_o,
  output logic signed [63:0]  energy_total_o
);

  typedef enum logic [2:0] {B_IDLE, B_DIV, B_SQRT, B_MUL, B_EMUL, B_PF, B_FIN} state_e;

  state_e             state_q;
  logic [1:0]         sel_q;
  logic [5:0]         step_q;
  logic [63:0]        dvd_q, sum_v_q, xmag_q, mean_i_q, mean_v_q, mag_q;
  logic [16:0]        rem_q, n_q;
  logic               neg_q, clamp_q;
  logic [63:0]        sqn_q, sqr_q, sqbit_q;
  logic [31:0]        irms_q, vrms_q;
  logic [63:0]        s_q, pfr_q;
  logic [14:0]        pfq_q;
  logic signed [39:0] rp_q;
  logic signed [56:0] e_q;
  logic signed [63:0] energy_q;
  logic               out_valid_q;
  logic [31:0]        vrms_out_q, irms_out_q;
  logic signed [39:0] rp_out_q;
  logic signed [15:0] pf_out_q;

  // division step
  logic [17:0] rem2;
  logic        dge;
  logic [16:0] rem_nx;
  assign rem2   = {rem_q, dvd_q[63]};
  assign dge    = rem2 >= {1'b0, n_q};
  assign rem_nx = dge ? 17'(rem2 - {1'b0, n_q}) : rem2[16:0];

  // square root step
  logic [63:0] rb;
  logic        sge;
  assign rb  = sqr_q + sqbit_q;
  assign sge = sqn_q >= rb;

  // power factor step
  logic [64:0] pr2;
  logic        pge;
  assign pr2 = {pfr_q, 1'b0};
  assign pge = pr2 >= {1'b0, s_q};

  logic signed [63:0] p32, p16;
  assign p32 = neg_q ? -$signed(mag_q) : $signed(mag_q);
  assign p16 = p32 >>> 16;

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  assign pop_o          = (state_q == B_IDLE) && valid_i;
  assign out_valid_o    = out_valid_q;
  assign vrms_o         = vrms_out_q;
  assign irms_o         = irms_out_q;
  assign real_power_o   = rp_out_q;
  assign power_factor_o = pf_out_q;
  assign energy_total_o = energy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      sel_q       <= '0;
      step_q      <= '0;
      energy_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          if (valid_i) begin
            dvd_q   <= data_i.sum_i;
            sum_v_q <= data_i.sum_v;
            neg_q   <= data_i.sum_x[63];
            xmag_q  <= data_i.sum_x[63] ? 64'(-data_i.sum_x) : data_i.sum_x;
            n_q     <= data_i.n;
            rem_q   <= '0;
            sel_q   <= 2'd0;
            step_q  <= '0;
            state_q <= B_DIV;
          end
        end
        B_DIV: begin
          rem_q  <= rem_nx;
          dvd_q  <= {dvd_q[62:0], dge};
          step_q <= step_q + 6'd1;
          if (step_q == 6'd63) begin
            rem_q <= '0;
            unique case (sel_q)
              2'd0: begin
                mean_i_q <= {dvd_q[62:0], dge};
                dvd_q    <= sum_v_q;
                sel_q    <= 2'd1;
              end
              2'd1: begin
                mean_v_q <= {dvd_q[62:0], dge};
                dvd_q    <= xmag_q;
                sel_q    <= 2'd2;
              end
              default: begin
                mag_q   <= {dvd_q[62:0], dge};
                sqn_q   <= mean_i_q;
                sqr_q   <= '0;
                sqbit_q <= 64'd1 << 62;
                sel_q   <= 2'd0;
                state_q <= B_SQRT;
              end
            endcase
          end
        end
        B_SQRT: begin
          if (sge) begin
            sqn_q <= sqn_q - rb;
            sqr_q <= (sqr_q >> 1) + sqbit_q;
          end else begin
            sqr_q <= sqr_q >> 1;
          end
          sqbit_q <= sqbit_q >> 2;
          step_q  <= step_q + 6'd1;
          if (step_q[4:0] == 5'd31) begin
            step_q  <= '0;
            sqn_q   <= mean_v_q;
            sqr_q   <= '0;
            sqbit_q <= 64'd1 << 62;
            if (sel_q == 2'd0) begin
              irms_q <= sge ? 32'((sqr_q >> 1) + sqbit_q) : 32'(sqr_q >> 1);
              sel_q  <= 2'd1;
            end else begin
              vrms_q  <= sge ? 32'((sqr_q >> 1) + sqbit_q) : 32'(sqr_q >> 1);
              state_q <= B_MUL;
            end
          end
        end
        B_MUL: begin
          s_q <= 64'(vrms_q) * 64'(irms_q) + pmfe_pkg::EPS_Q32;
          if (p16 > 64'sd549755813887) begin
            rp_q <= 40'sh7fffffffff;
          end else if (p16 < -64'sd549755813888) begin
            rp_q <= 40'sh8000000000;
          end else begin
            rp_q <= p16[39:0];
          end
          state_q <= B_EMUL;
        end
        B_EMUL: begin
          e_q     <= 57'(rp_q) * $signed({1'b0, window_ms_i});
          clamp_q <= mag_q >= s_q;
          pfr_q   <= mag_q;
          pfq_q   <= '0;
          step_q  <= '0;
          state_q <= B_PF;
        end
        B_PF: begin
          if (clamp_q || step_q == 6'd15) begin
            state_q <= B_FIN;
          end else begin
            pfr_q  <= pge ? 64'(pr2 - {1'b0, s_q}) : pfr_q << 1;
            pfq_q  <= {pfq_q[13:0], pge};
            step_q <= step_q + 6'd1;
          end
        end
        B_FIN: begin
          if (out_free) begin
            vrms_out_q  <= vrms_q;
            irms_out_q  <= irms_q;
            rp_out_q    <= rp_q;
            if (clamp_q) begin
              pf_out_q <= neg_q ? 16'sh8000 : 16'sh7fff;
            end else begin
              pf_out_q <= neg_q ? -$signed({1'b0, pfq_q}) : $signed({1'b0, pfq_q});
            end
            energy_q    <= pmfe_pkg::sadd_sat(energy_q, 64'(e_q));
            out_valid_q <= 1'b1;
            state_q     <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == B_PF) |-> (step_q <= 6'd15))
    else $error("power factor step count overrun");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == B_SQRT) |-> $onehot(sqbit_q))
    else $error("square root bit lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == B_FIN && out_valid_q && !out_ready_i) |=> $stable(energy_q))
    else $error("energy updated while result held");

endmodule

@@ src/power_metering_front_end.sv @@
// Top level of the power metering front end: register file and the three parts.
// Depends on pmfe_pkg, pmfe_front, pmfe_fifo and pmfe_back.
//
//  channel  signals                                   direction
//  in       in_valid_i/in_ready_o, current/voltage    sample pairs in
//  out      out_valid_o/out_ready_i, vrms..energy     one item per window
//  cfg      cfg_we_i, cfg_idx_i, cfg_data_i            register writes
//
// A sample pair passes the sample path in steps (accept, high-pass, gain,
// lag, products, sums); the next pair is accepted only after the sums step.
// Window math runs three 64-step serial divisions, two 32-step square roots
// and up to 15 power factor steps, one window at a time.
// A two-entry queue holds closed windows; a closing window stalls sampling while the queue is full.
// Reset clears all filters, sums, energy and loads the default registers.
module power_metering_front_end #(
  parameter int AdcWidth = pmfe_pkg::ADC_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pmfe_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pmfe_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [AdcWidth-1:0]              current_code_i,
  input  logic [AdcWidth-1:0]              voltage_code_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [31:0]                      vrms_o,
  output logic [31:0]                      irms_o,
  output logic signed [39:0]               real_power_o,
  output logic signed [15:0]               power_factor_o,
  output logic signed [63:0]               energy_total_o
);

  pmfe_pkg::cfg_t cfg_q;
  pmfe_pkg::win_t push_data, pop_data;
  logic           push, full, pop, qvalid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mid_code       <= pmfe_pkg::MID_CODE_RST;
      cfg_q.hpf_coef       <= pmfe_pkg::HPF_COEF_RST;
      cfg_q.phase_coef     <= pmfe_pkg::PHASE_COEF_RST;
      cfg_q.voltage_gain   <= pmfe_pkg::V_GAIN_RST;
      cfg_q.current_gain   <= pmfe_pkg::I_GAIN_RST;
      cfg_q.window_samples <= pmfe_pkg::WIN_SMP_RST;
      cfg_q.window_ms      <= pmfe_pkg::WIN_MS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pmfe_pkg::CFG_MID_CODE:   cfg_q.mid_code       <= cfg_data_i[11:0];
        pmfe_pkg::CFG_HPF_COEF:   cfg_q.hpf_coef       <= cfg_data_i[15:0];
        pmfe_pkg::CFG_PHASE_COEF: cfg_q.phase_coef     <= cfg_data_i[13:0];
        pmfe_pkg::CFG_V_GAIN:     cfg_q.voltage_gain   <= cfg_data_i;
        pmfe_pkg::CFG_I_GAIN:     cfg_q.current_gain   <= cfg_data_i;
        pmfe_pkg::CFG_WIN_SMP:    cfg_q.window_samples <= cfg_data_i[15:0];
        pmfe_pkg::CFG_WIN_MS:     cfg_q.window_ms      <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  pmfe_front #(.AdcWidth(AdcWidth)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .current_code_i (current_code_i),
    .voltage_code_i (voltage_code_i),
    .push_o         (push),
    .push_data_o    (push_data),
    .full_i         (full)
  );

  pmfe_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (qvalid),
    .pop_data_o  (pop_data)
  );

  pmfe_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .window_ms_i    (cfg_q.window_ms),
    .valid_i        (qvalid),
    .data_i         (pop_data),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .vrms_o         (vrms_o),
    .irms_o         (irms_o),
    .real_power_o   (real_power_o),
    .power_factor_o (power_factor_o),
    .energy_total_o (energy_total_o)
  );

endmodule

@@ test/power_metering_front_end_tb.sv @@
// Self-checking testbench for power_metering_front_end: sample pairs in, window results out.
// Predicts each window result with a fixed-point metering model; depends on pmfe_pkg.
`timescale 1ns / 1ps

module power_metering_front_end_tb;

  localparam int AW = pmfe_pkg::ADC_WIDTH_DEF;
  localparam logic [pmfe_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
  localparam int SETTLE_CYCLES = 400;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [AW-1:0] cur;
    logic [AW-1:0] volt;
  } sample_t;

  typedef struct {
    logic [31:0]        vrms;
    logic [31:0]        irms;
    logic signed [39:0] power;
    logic signed [15:0] pf;
    logic signed [63:0] energy;
  } reading_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [pmfe_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [pmfe_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [AW-1:0] current_code_i = '0;
  logic [AW-1:0] voltage_code_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [31:0] vrms_o, irms_o;
  logic signed [39:0] real_power_o;
  logic signed [15:0] power_factor_o;
  logic signed [63:0] energy_total_o;

  power_metering_front_end dut (.*);

  initial forever #5 clk_i = ~clk_i;

  // model registers and state
  pmfe_pkg::cfg_t m_cfg;
  int m_hpi, m_hpv, m_previ, m_prevv, m_lag;
  logic [63:0] m_sum_i, m_sum_v;
  logic signed [63:0] m_sum_x, m_energy;
  logic [15:0] m_count;

  sample_t pending_samples[$];
  reading_t expected_readings[$];
  bit failed = 1'b0;
  bit no_idle = 1'b0;
  bit in_fire = 1'b0;
  bit hold_req = 1'b0, hold_seen = 1'b0;
  int hold_cnt = 0;
  int cycles = 0;

  function automatic int clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic logic [63:0] uadd_clip(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  function automatic logic signed [63:0] sadd_clip(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  function automatic logic [31:0] root_floor(logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[31:0];
  endfunction

  function automatic int highpass_step(inout int y, inout int prev, input int x);
    longint t, p;
    t = longint'(y) + longint'(x - prev) * 64'sd65536;
    p = t * longint'(m_cfg.hpf_coef) + 64'sd32768;
    y = clip32(p >>> 16);
    prev = x;
    return y;
  endfunction

  function automatic bit meter_sample(input sample_t smp, output reading_t rd);
    int xi, xv, yi, yv, ia, vv;
    longint d, ip;
    logic signed [63:0] p32, rp;
    logic [63:0] n, s, mag, r;
    logic [15:0] q, win;
    bit top;
    xi = int'(smp.cur) - int'(m_cfg.mid_code);
    xv = int'(smp.volt) - int'(m_cfg.mid_code);
    yi = highpass_step(m_hpi, m_previ, xi);
    yv = highpass_step(m_hpv, m_prevv, xv);
    ia = clip32((longint'(yi) * longint'(m_cfg.current_gain)) >>> 24);
    vv = clip32((longint'(yv) * longint'(m_cfg.voltage_gain)) >>> 24);
    d = longint'(m_lag) - longint'(ia);
    m_lag = clip32(longint'(ia) + ((d * longint'(m_cfg.phase_coef) + 64'sd32768) >>> 16));
    ip = longint'(m_lag);
    m_sum_i = uadd_clip(m_sum_i, 64'(ip * ip));
    m_sum_v = uadd_clip(m_sum_v, 64'(longint'(vv) * longint'(vv)));
    m_sum_x = sadd_clip(m_sum_x, longint'(vv) * ip);
    m_count = m_count + 16'd1;
    win = (m_cfg.window_samples == 0) ? 16'd1 : m_cfg.window_samples;
    if (m_count < win && m_count != 0) return 1'b0;
    n = (m_count == 0) ? 64'd65536 : {48'd0, m_count};
    rd.irms = root_floor(m_sum_i / n);
    rd.vrms = root_floor(m_sum_v / n);
    p32 = m_sum_x / $signed(n);
    rp = p32 >>> 16;
    if (rp > 64'sd549755813887) rp = 64'sd549755813887;
    if (rp < -64'sd549755813888) rp = -64'sd549755813888;
    s = {32'd0, rd.vrms} * {32'd0, rd.irms} + pmfe_pkg::EPS_Q32;
    mag = p32[63] ? (~p32 + 64'd1) : p32;
    if (mag >= s) begin
      rd.pf = p32[63] ? 16'sh8000 : 16'sh7fff;
    end else begin
      r = mag;
      q = 0;
      for (int b = 0; b < 15; b++) begin
        top = r[63];
        r = r << 1;
        q = q << 1;
        if (top || r >= s) begin
          r = r - s;
          q[0] = 1'b1;
        end
      end
      rd.pf = p32[63] ? -$signed(q) : $signed(q);
    end
    m_energy = sadd_clip(m_energy, rp * longint'(m_cfg.window_ms));
    rd.power = rp[39:0];
    rd.energy = m_energy;
    m_sum_i = 0;
    m_sum_v = 0;
    m_sum_x = 0;
    m_count = 0;
    return 1'b1;
  endfunction

  task automatic write_reg(logic [pmfe_pkg::CFG_IDX_W-1:0] idx,
                           logic [pmfe_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    case (idx)
      pmfe_pkg::CFG_MID_CODE:   m_cfg.mid_code = val[11:0];
      pmfe_pkg::CFG_HPF_COEF:   m_cfg.hpf_coef = val[15:0];
      pmfe_pkg::CFG_PHASE_COEF: m_cfg.phase_coef = val[13:0];
      pmfe_pkg::CFG_V_GAIN:     m_cfg.voltage_gain = val;
      pmfe_pkg::CFG_I_GAIN:     m_cfg.current_gain = val;
      pmfe_pkg::CFG_WIN_SMP:    m_cfg.window_samples = val[15:0];
      pmfe_pkg::CFG_WIN_MS:     m_cfg.window_ms = val[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic drain();
    wait (pending_samples.size() == 0 && !in_valid_i && expected_readings.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_sample(int c, int v);
    sample_t smp;
    smp.cur = c[AW-1:0];
    smp.volt = v[AW-1:0];
    pending_samples.push_back(smp);
  endtask

  // mostly a noisy triangle-wave pair around mid rail, sometimes raw noise
  task automatic push_wave(int count, bit noise);
    int amp_v, amp_i, ph, saw;
    amp_v = $urandom_range(0, 2047);
    amp_i = $urandom_range(0, 2047);
    ph = $urandom_range(0, 63);
    for (int k = 0; k < count; k++) begin
      saw = ((k + ph) % 32 < 16) ? ((k + ph) % 16) - 8 : 8 - ((k + ph) % 16);
      if (noise || $urandom_range(0, 19) == 0)
        push_sample($urandom_range(0, 4095), $urandom_range(0, 4095));
      else
        push_sample(2048 + saw * amp_i / 8 + $urandom_range(0, 15),
                    2048 + saw * amp_v / 8 + $urandom_range(0, 15));
    end
  endtask

  function automatic int pick(int hi);
    case ($urandom_range(0, 7))
      0: return 0;
      1: return hi;
      default: return $urandom_range(0, hi);
    endcase
  endfunction

  // sender
  always @(negedge clk_i) begin
    if (!in_valid_i || in_fire) begin
      if (pending_samples.size() != 0 && (no_idle || $urandom_range(0, 99) >= 11)) begin
        current_code_i <= pending_samples[0].cur;
        voltage_code_i <= pending_samples[0].volt;
        void'(pending_samples.pop_front());
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    sample_t smp;
    reading_t rd;
    in_fire <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o) begin
      smp.cur = current_code_i;
      smp.volt = voltage_code_i;
      if (meter_sample(smp, rd)) expected_readings.push_back(rd);
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_cnt = 3000;
    end
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= no_idle || $urandom_range(0, 99) >= 11;
    end
  end

  always @(posedge clk_i) begin
    reading_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected item vrms=%h", $time, vrms_o);
        failed = 1'b1;
      end else begin
        e = expected_readings.pop_front();
        if (vrms_o !== e.vrms) begin
          $display("%0t: vrms exp %h got %h", $time, e.vrms, vrms_o);
          failed = 1'b1;
        end
        if (irms_o !== e.irms) begin
          $display("%0t: irms exp %h got %h", $time, e.irms, irms_o);
          failed = 1'b1;
        end
        if (real_power_o !== e.power) begin
          $display("%0t: real_power exp %h got %h", $time, e.power, real_power_o);
          failed = 1'b1;
        end
        if (power_factor_o !== e.pf) begin
          $display("%0t: power_factor exp %h got %h", $time, e.pf, power_factor_o);
          failed = 1'b1;
        end
        if (energy_total_o !== e.energy) begin
          $display("%0t: energy_total exp %h got %h", $time, e.energy, energy_total_o);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    m_cfg = '{pmfe_pkg::MID_CODE_RST, pmfe_pkg::HPF_COEF_RST, pmfe_pkg::PHASE_COEF_RST,
              pmfe_pkg::V_GAIN_RST, pmfe_pkg::I_GAIN_RST, pmfe_pkg::WIN_SMP_RST,
              pmfe_pkg::WIN_MS_RST};
    m_hpi = 0; m_hpv = 0; m_previ = 0; m_prevv = 0; m_lag = 0;
    m_sum_i = 0; m_sum_v = 0; m_sum_x = 0; m_count = 0; m_energy = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: code extremes at max gains, window of one
    write_reg(pmfe_pkg::CFG_WIN_SMP, 0);
    write_reg(pmfe_pkg::CFG_V_GAIN, 24'hffffff);
    write_reg(pmfe_pkg::CFG_I_GAIN, 24'hffffff);
    write_reg(pmfe_pkg::CFG_HPF_COEF, 16'hffff);
    write_reg(pmfe_pkg::CFG_PHASE_COEF, 14'h3fff);
    write_reg(pmfe_pkg::CFG_WIN_MS, 16'hffff);
    write_reg(CFG_IDX_UNUSED, 24'hffffff);
    push_sample(0, 4095); push_sample(4095, 0); push_sample(4095, 4095);
    push_sample(0, 0); push_sample(2048, 2048); push_sample(4095, 0);
    drain();
    write_reg(pmfe_pkg::CFG_MID_CODE, 0);
    write_reg(pmfe_pkg::CFG_HPF_COEF, 0);
    write_reg(pmfe_pkg::CFG_PHASE_COEF, 0);
    write_reg(pmfe_pkg::CFG_WIN_MS, 0);
    write_reg(pmfe_pkg::CFG_WIN_SMP, 2);
    push_sample(4095, 4095); push_sample(0, 0); push_sample(4095, 0); push_sample(0, 4095);
    drain();
    // longest window, then shortened below the current count
    write_reg(pmfe_pkg::CFG_MID_CODE, 4095);
    write_reg(pmfe_pkg::CFG_HPF_COEF, 65208);
    write_reg(pmfe_pkg::CFG_PHASE_COEF, 13107);
    write_reg(pmfe_pkg::CFG_V_GAIN, 0);
    write_reg(pmfe_pkg::CFG_I_GAIN, 0);
    write_reg(pmfe_pkg::CFG_WIN_MS, 1);
    write_reg(pmfe_pkg::CFG_WIN_SMP, 16'hffff);
    push_wave(6, 1'b0);
    drain();
    write_reg(pmfe_pkg::CFG_V_GAIN, 2568811);
    write_reg(pmfe_pkg::CFG_I_GAIN, 12033);
    write_reg(pmfe_pkg::CFG_WIN_SMP, 3);
    push_wave(7, 1'b0);
    drain();

    for (int ph = 0; ph < 16; ph++) begin
      write_reg(pmfe_pkg::CFG_MID_CODE, ($urandom_range(0, 3) == 0) ? pick(4095) : 2048);
      write_reg(pmfe_pkg::CFG_HPF_COEF, ($urandom_range(0, 3) == 0)
                                        ? pick(65535) : $urandom_range(60000, 65535));
      write_reg(pmfe_pkg::CFG_PHASE_COEF, pick(16383));
      write_reg(pmfe_pkg::CFG_V_GAIN, pick(24'hffffff));
      write_reg(pmfe_pkg::CFG_I_GAIN, pick(24'hffffff));
      write_reg(pmfe_pkg::CFG_WIN_SMP, ($urandom_range(0, 4) == 0)
                                       ? $urandom_range(0, 60) : $urandom_range(1, 8));
      write_reg(pmfe_pkg::CFG_WIN_MS, pick(65535));
      no_idle = (ph == 5);
      if (ph == 8) hold_req = ~hold_req;
      push_wave(110, $urandom_range(0, 4) == 0);
      if (ph % 4 == 3) begin
        drain();
      end
      push_wave($urandom_range(0, 10), 1'b1);
      drain();
    end
    no_idle = 1'b0;
    drain();

    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
